[rtl/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// bffa_pkg
// shared constants, codes and controller/datapath bundles for the bitmap
// first-fit allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int unsigned DATA_MAP_BITS_DEF  = 8192;
  localparam int unsigned INODE_MAP_BITS_DEF = 1024;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned DCNT_W    = 14;
  localparam int unsigned ICNT_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned STAT_W    = 2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd2;

  localparam logic [NUM_W-1:0]  DATA_BASE_RST   = 32'd0;
  localparam logic [DCNT_W-1:0] DATA_COUNT_RST  = 14'd8192;
  localparam logic [ICNT_W-1:0] INODE_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic              clr;        // clearing pass write
    logic              start;      // word accepted, latch request
    logic              scan;       // advance the allocate scan pipeline
    logic              frd;        // read the word holding the bit to free
    logic              fin;        // finish request with fin_status
    logic [STAT_W-1:0] fin_status;
    logic              wr;         // commit updated map word
    logic              res_ld;     // move pending result to output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_free;
    logic lim_zero;
    logic range_bad;
    logic scan_hit;
    logic scan_miss;
    logic bit_used;
    logic out_free;
  } sts_t;

  // index of the lowest set bit of a map word
  function automatic logic [5:0] low_index(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] oh;
    logic [5:0]           r;
    oh = v & (~v + 64'd1);
    r  = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        r = r | 6'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/bffa_ctrl.sv]
// ----------------------------------------------------------------------------
// bffa_ctrl
// request sequencer: clearing pass, allocate scan, free check and result
// hand-off to the output register
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  bffa_pkg::sts_t sts_i,
  output bffa_pkg::cmd_t cmd_o
);
  import bffa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FRD   = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.in_free ? S_FRD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.lim_zero) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_FULL;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan = 1'b1;
          if (sts_i.scan_hit) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_OK;
            cmd_o.wr         = 1'b1;
            state_d          = S_DONE;
          end else if (sts_i.scan_miss) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_FULL;
            state_d          = S_DONE;
          end
        end
      end
      S_FRD: begin
        if (sts_i.range_bad) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_RANGE;
          state_d          = S_DONE;
        end else begin
          cmd_o.frd = 1'b1;
          state_d   = S_FCHK;
        end
      end
      S_FCHK: begin
        cmd_o.fin = 1'b1;
        if (sts_i.bit_used) begin
          cmd_o.fin_status = ST_OK;
          cmd_o.wr         = 1'b1;
        end else begin
          cmd_o.fin_status = ST_DOUBLE;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // a hit in the scan always commits the word with the bit set
  a_hit_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !sts_i.lim_zero && sts_i.scan_hit) |-> cmd_o.wr)
    else $error("scan hit without map write");
  // nothing is taken while the clearing pass runs
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr |-> !cmd_o.start)
    else $error("word accepted during clearing pass");
`endif

endmodule

[rtl/bffa_dp.sv]
// ----------------------------------------------------------------------------
// bffa_dp
// free-map memories, configuration registers, word scan pipeline, free check
// and output register
// ----------------------------------------------------------------------------
module bffa_dp #(
  parameter int unsigned DATA_MAP_BITS  = bffa_pkg::DATA_MAP_BITS_DEF,
  parameter int unsigned INODE_MAP_BITS = bffa_pkg::INODE_MAP_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bffa_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic [bffa_pkg::NUM_W-1:0]        s_tdata_i,
  input  logic [1:0]                        s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [bffa_pkg::NUM_W-1:0]        m_tdata_o,
  output logic [bffa_pkg::STAT_W-1:0]       m_tuser_o,
  input  bffa_pkg::cmd_t                    cmd_i,
  output bffa_pkg::sts_t                    sts_o
);
  import bffa_pkg::*;

  localparam int unsigned DW   = (DATA_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned IW   = (INODE_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned DAW  = (DW > 1) ? $clog2(DW) : 1;
  localparam int unsigned IAW  = (IW > 1) ? $clog2(IW) : 1;
  localparam int unsigned WW   = (DAW > IAW) ? DAW : IAW;
  localparam int unsigned NCLR = (DW > IW) ? DW : IW;
  localparam int unsigned CW   = (NCLR > 1) ? $clog2(NCLR) : 1;
  localparam logic [NUM_W-1:0] DBITS = NUM_W'(DATA_MAP_BITS);
  localparam logic [NUM_W-1:0] IBITS = NUM_W'(INODE_MAP_BITS);

  // configuration
  logic [NUM_W-1:0]  data_base_q;
  logic [DCNT_W-1:0] data_count_q;
  logic [ICNT_W-1:0] inode_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q   <= DATA_BASE_RST;
      data_count_q  <= DATA_COUNT_RST;
      inode_count_q <= INODE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DATA_BASE:   data_base_q   <= cfg_data_i;
        REG_DATA_COUNT:  data_count_q  <= cfg_data_i[DCNT_W-1:0];
        REG_INODE_COUNT: inode_count_q <= cfg_data_i[ICNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request registers
  logic             req_q;    // 1 free
  logic             pool_q;   // 1 inode
  logic [NUM_W-1:0] fidx_q;   // bit index for a free

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= s_tuser_i[0];
      pool_q <= s_tuser_i[1];
      fidx_q <= s_tuser_i[1] ? s_tdata_i : s_tdata_i - data_base_q;
    end
  end

  // effective limits
  logic [NUM_W-1:0] dcnt, icnt, dlim, ilim, lim, lim_m1;
  logic [WW-1:0]    last_word;

  assign dcnt      = NUM_W'(data_count_q);
  assign icnt      = NUM_W'(inode_count_q);
  assign dlim      = (dcnt >= DBITS) ? DBITS : dcnt;
  assign ilim      = (icnt >= IBITS) ? IBITS : icnt;
  assign lim       = pool_q ? ilim : dlim;
  assign lim_m1    = lim - 32'd1;
  assign last_word = lim_m1[6 +: WW];

  // clearing pass
  logic [CW-1:0] clr_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_ptr_q <= clr_ptr_q + CW'(1);
    end
  end

  // scan pipeline: issue one word read per cycle, check it the next
  logic [WW-1:0] rd_ptr_q, chk_ptr_q;
  logic          rd_run_q, chk_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_run_q  <= 1'b0;
      chk_vld_q <= 1'b0;
      rd_ptr_q  <= '0;
      chk_ptr_q <= '0;
    end else if (cmd_i.start) begin
      rd_run_q  <= 1'b1;
      chk_vld_q <= 1'b0;
      rd_ptr_q  <= '0;
    end else if (cmd_i.scan) begin
      chk_vld_q <= rd_run_q;
      if (rd_run_q) begin
        chk_ptr_q <= rd_ptr_q;
        if (rd_ptr_q == last_word) begin
          rd_run_q <= 1'b0;
        end else begin
          rd_ptr_q <= rd_ptr_q + WW'(1);
        end
      end
    end
  end

  // memories
  logic                 scan_rd, op_re, op_we;
  logic                 d_we, d_re, i_we, i_re;
  logic [DAW-1:0]       d_wa, d_ra;
  logic [IAW-1:0]       i_wa, i_ra;
  logic [WW-1:0]        op_ra, op_wa;
  logic [WORD_BITS-1:0] wd, d_rd_q, i_rd_q, rd_word;
  logic [WORD_BITS-1:0] d_mem [DW];
  logic [WORD_BITS-1:0] i_mem [IW];

  assign scan_rd = cmd_i.scan && rd_run_q;
  assign op_re   = scan_rd || cmd_i.frd;
  assign op_ra   = cmd_i.frd ? fidx_q[6 +: WW] : rd_ptr_q;
  assign op_wa   = req_q ? fidx_q[6 +: WW] : chk_ptr_q;
  assign op_we   = cmd_i.wr;

  assign d_re = op_re && !pool_q;
  assign i_re = op_re && pool_q;
  assign d_ra = op_ra[DAW-1:0];
  assign i_ra = op_ra[IAW-1:0];
  assign d_we = cmd_i.clr ? (NUM_W'(clr_ptr_q) < NUM_W'(DW)) : (op_we && !pool_q);
  assign i_we = cmd_i.clr ? (NUM_W'(clr_ptr_q) < NUM_W'(IW)) : (op_we && pool_q);
  assign d_wa = cmd_i.clr ? clr_ptr_q[DAW-1:0] : op_wa[DAW-1:0];
  assign i_wa = cmd_i.clr ? clr_ptr_q[IAW-1:0] : op_wa[IAW-1:0];

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      d_mem[d_wa] <= wd;
    end
    if (d_re) begin
      d_rd_q <= d_mem[d_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (i_we) begin
      i_mem[i_wa] <= wd;
    end
    if (i_re) begin
      i_rd_q <= i_mem[i_ra];
    end
  end

  assign rd_word = pool_q ? i_rd_q : d_rd_q;

  // word check
  logic [WORD_BITS-1:0] mask, avail, first_oh, free_bit;
  logic [5:0]           bidx;
  logic [NUM_W-1:0]     alloc_num;

  always_comb begin
    if (chk_ptr_q == last_word && lim[5:0] != 6'd0) begin
      mask = (64'd1 << lim[5:0]) - 64'd1;
    end else begin
      mask = '1;
    end
  end

  assign avail     = ~rd_word & mask;
  assign first_oh  = avail & (~avail + 64'd1);
  assign bidx      = low_index(avail);
  assign free_bit  = 64'd1 << fidx_q[5:0];
  assign alloc_num = NUM_W'({chk_ptr_q, bidx}) + (pool_q ? '0 : data_base_q);
  assign wd        = cmd_i.clr ? '0 :
                     (req_q ? (rd_word & ~free_bit) : (rd_word | first_oh));

  // pending result and output register
  logic [STAT_W-1:0] pend_stat_q, out_stat_q;
  logic [NUM_W-1:0]  pend_num_q, out_num_q;
  logic              out_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      pend_stat_q <= cmd_i.fin_status;
      pend_num_q  <= (!req_q && cmd_i.fin_status == ST_OK) ? alloc_num : '0;
    end
    if (cmd_i.res_ld) begin
      out_stat_q <= pend_stat_q;
      out_num_q  <= pend_num_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_num_q;
  assign m_tuser_o  = out_stat_q;

  always_comb begin
    sts_o           = '0;
    sts_o.clr_done  = (clr_ptr_q == CW'(NCLR - 1));
    sts_o.in_free   = s_tuser_i[0];
    sts_o.lim_zero  = (lim == '0);
    sts_o.range_bad = (fidx_q >= lim);
    sts_o.scan_hit  = chk_vld_q && (avail != '0);
    sts_o.scan_miss = chk_vld_q && (avail == '0) && (chk_ptr_q == last_word);
    sts_o.bit_used  = rd_word[fidx_q[5:0]];
    sts_o.out_free  = !out_vld_q || m_tready_i;
  end

`ifndef ASSERT_OFF
  a_res_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_ld |=> out_vld_q)
    else $error("loaded result not presented");
  a_d_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_we && d_re) |-> (d_wa != d_ra))
    else $error("data map read and write hit the same word");
  a_start_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> !chk_vld_q)
    else $error("stale word in scan pipeline after start");
  a_ok_alloc_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && cmd_i.fin_status == ST_OK && !req_q) |-> sts_o.scan_hit)
    else $error("allocate success without a clear bit found");
`endif

endmodule

[rtl/bitmap_first_fit_allocator.sv]
// An allocate scans from word 0 to the word holding its clear bit, or to the last word in
// the limit when full; a zero count gives full with no map read. A free reads the word of
// its bit, or none when out of range. A busy output register adds its stall.
// Throughput: one word in flight; the next is taken the cycle after the
// result moves to the output register, the scan reads one 64-bit map word per cycle.
// Reset clears both maps in a pass over max(data words, inode words) word addresses,
// 128 at default sizes, during which no word is accepted.
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// data block and inode free-maps with lowest-free allocate and checked free
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator #(
  parameter int unsigned DATA_MAP_BITS  = bffa_pkg::DATA_MAP_BITS_DEF,
  parameter int unsigned INODE_MAP_BITS = bffa_pkg::INODE_MAP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bffa_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bffa_pkg::NUM_W-1:0]     s_axis_tdata,   // [31:0] item_number
  input  logic [1:0]                     s_axis_tuser,   // [0] req_type, [1] pool
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bffa_pkg::NUM_W-1:0]     m_axis_tdata,   // [31:0] number
  output logic [bffa_pkg::STAT_W-1:0]    m_axis_tuser    // [1:0] status
);
  import bffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bffa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bffa_dp #(
    .DATA_MAP_BITS  (DATA_MAP_BITS),
    .INODE_MAP_BITS (INODE_MAP_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives allocate and free requests into the bitmap first-fit allocator,
// tracks both free-maps alongside it and checks every status and number
// ----------------------------------------------------------------------------
module testbench;
  import bffa_pkg::*;

  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_FREE   = 1'b1;
  localparam logic POOL_DATA  = 1'b0;
  localparam logic POOL_INODE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int unsigned IDLE_PCT     = 12;
  localparam int unsigned PHASE_WORDS  = 50;
  localparam int unsigned TAIL_CYCLES  = 200;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  number;
  } outcome_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [NUM_W-1:0]     s_axis_tdata  = '0;  // [31:0] item_number
  logic [1:0]           s_axis_tuser  = '0;  // [0] req_type, [1] pool
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [NUM_W-1:0]     m_axis_tdata;        // [31:0] number
  logic [STAT_W-1:0]    m_axis_tuser;        // [1:0] status

  // shadow free-maps and registers, updated as words are accepted
  bit [DATA_MAP_BITS_DEF-1:0]  data_used;
  bit [INODE_MAP_BITS_DEF-1:0] inode_used;
  logic [NUM_W-1:0]  base_q   = DATA_BASE_RST;
  logic [DCNT_W-1:0] dcount_q = DATA_COUNT_RST;
  logic [ICNT_W-1:0] icount_q = INODE_COUNT_RST;

  outcome_t    outcomes_due[$];
  int unsigned live_data[$];
  int unsigned live_inode[$];
  int unsigned mismatches = 0;
  bit          src_calm   = 1'b0;
  bit          snk_calm   = 1'b0;

  bitmap_first_fit_allocator #(
    .DATA_MAP_BITS (DATA_MAP_BITS_DEF),
    .INODE_MAP_BITS(INODE_MAP_BITS_DEF)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned data_limit();
    return (dcount_q < DATA_MAP_BITS_DEF) ? dcount_q : DATA_MAP_BITS_DEF;
  endfunction

  function automatic int unsigned inode_limit();
    return (icount_q < INODE_MAP_BITS_DEF) ? icount_q : INODE_MAP_BITS_DEF;
  endfunction

  // lowest-free allocate or checked free against the shadow maps
  function automatic outcome_t apply_request(input logic req, input logic pool,
                                             input logic [NUM_W-1:0] num);
    outcome_t         o;
    int unsigned      lim;
    int unsigned      idx;
    logic [NUM_W-1:0] off;
    bit               hit;
    o.status = ST_OK;
    o.number = '0;
    hit      = 1'b0;
    idx      = 0;
    lim      = (pool == POOL_DATA) ? data_limit() : inode_limit();
    if (req == REQ_ALLOC) begin
      for (int unsigned i = 0; i < lim && !hit; i++) begin
        if (pool == POOL_DATA ? !data_used[i] : !inode_used[i]) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (!hit) begin
        o.status = ST_FULL;
      end else if (pool == POOL_DATA) begin
        data_used[idx] = 1'b1;
        o.number = base_q + idx;
        live_data.push_back(idx);
      end else begin
        inode_used[idx] = 1'b1;
        o.number = idx;
        live_inode.push_back(idx);
      end
    end else begin
      // data numbers are offset by the base, wrapping at 32 bits
      off = (pool == POOL_DATA) ? num - base_q : num;
      if (off >= lim) begin
        o.status = ST_RANGE;
      end else if (pool == POOL_DATA ? !data_used[off] : !inode_used[off]) begin
        o.status = ST_DOUBLE;
      end else if (pool == POOL_DATA) begin
        data_used[off] = 1'b0;
      end else begin
        inode_used[off] = 1'b0;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [NUM_W-1:0] got,
                                 input logic [NUM_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic check_outcome();
    outcome_t want;
    if (outcomes_due.size() == 0) begin
      report_mismatch("unexpected word", m_axis_tdata, '0);
    end else begin
      want = outcomes_due.pop_front();
      if (m_axis_tuser !== want.status) begin
        report_mismatch("status", m_axis_tuser, want.status);
      end
      if (m_axis_tdata !== want.number) begin
        report_mismatch("number", m_axis_tdata, want.number);
      end
    end
  endtask

  // result side: check at each accepted word, then pick the next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      check_outcome();
    end
    m_axis_tready <= snk_calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_request(input logic req, input logic pool,
                              input logic [NUM_W-1:0] num, output outcome_t due);
    while (!src_calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= num;
    s_axis_tuser  <= {pool, req};
    do @(posedge clk_i); while (!s_axis_tready);
    due = apply_request(req, pool, num);
    outcomes_due.push_back(due);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // count registers get random upper bits, only the low field is kept
  task automatic configure(input logic [NUM_W-1:0] base, input int unsigned dcnt,
                           input int unsigned icnt, input bit spare);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DATA_BASE;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx_i  <= REG_DATA_COUNT;
    cfg_data_i <= ($urandom << DCNT_W) | dcnt[DCNT_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= REG_INODE_COUNT;
    cfg_data_i <= ($urandom << ICNT_W) | icnt[ICNT_W-1:0];
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i  <= REG_SPARE;
      cfg_data_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    base_q   = base;
    dcount_q = dcnt[DCNT_W-1:0];
    icount_q = icnt[ICNT_W-1:0];
  endtask

  // number of a block or inode handed out earlier; keep leaves it for a double free
  function automatic logic [NUM_W-1:0] pick_live(input logic pool, input bit keep);
    int unsigned k;
    int unsigned idx;
    if (pool == POOL_DATA) begin
      if (live_data.size() == 0) return base_q + $urandom_range(dcount_q + 2);
      k   = $urandom_range(live_data.size() - 1);
      idx = live_data[k];
      if (!keep) live_data.delete(k);
      return base_q + idx;
    end
    if (live_inode.size() == 0) return $urandom_range(icount_q + 2);
    k   = $urandom_range(live_inode.size() - 1);
    idx = live_inode[k];
    if (!keep) live_inode.delete(k);
    return idx;
  endfunction

  task automatic random_request();
    outcome_t         got;
    logic             pool;
    int unsigned      roll;
    logic [NUM_W-1:0] num;
    pool = 1'($urandom_range(1));
    roll = $urandom_range(99);
    num  = $urandom;
    if (roll < 45) begin
      send_request(REQ_ALLOC, pool, num, got);
    end else begin
      if (roll < 75) begin
        num = pick_live(pool, 1'b0);
      end else if (roll < 82) begin
        num = pick_live(pool, 1'b1);
      end else if (roll < 92) begin
        num = (pool == POOL_DATA) ? base_q + $urandom_range(dcount_q + 2)
                                  : $urandom_range(icount_q + 2);
      end
      send_request(REQ_FREE, pool, num, got);
    end
  endtask

  task automatic test_directed();
    outcome_t got;
    // reset register values: full-size pools, zero base
    send_request(REQ_ALLOC, POOL_DATA, '1, got);
    send_request(REQ_ALLOC, POOL_INODE, '1, got);
    send_request(REQ_FREE, POOL_DATA, 32'd0, got);
    send_request(REQ_FREE, POOL_DATA, 32'd0, got);
    send_request(REQ_FREE, POOL_DATA, DATA_MAP_BITS_DEF, got);
    send_request(REQ_FREE, POOL_DATA, '1, got);
    send_request(REQ_FREE, POOL_INODE, INODE_MAP_BITS_DEF, got);
    send_request(REQ_FREE, POOL_INODE, INODE_MAP_BITS_DEF - 1, got);
    send_request(REQ_FREE, POOL_INODE, 32'd0, got);
    send_request(REQ_ALLOC, POOL_DATA, 32'd0, got);
    wait_for_results();
    // zero counts: nothing to hand out, nothing freeable
    configure(32'd0, 0, 0, 1'b1);
    send_request(REQ_ALLOC, POOL_DATA, $urandom, got);
    send_request(REQ_ALLOC, POOL_INODE, $urandom, got);
    send_request(REQ_FREE, POOL_DATA, 32'd0, got);
    send_request(REQ_FREE, POOL_INODE, 32'd0, got);
    wait_for_results();
    // base near the top so data numbers wrap past zero
    configure(32'hFFFF_FFFE, 4, 2, 1'b0);
    repeat (5) send_request(REQ_ALLOC, POOL_DATA, $urandom, got);
    send_request(REQ_FREE, POOL_DATA, 32'd0, got);
    send_request(REQ_FREE, POOL_DATA, 32'hFFFF_FFFD, got);
    repeat (3) send_request(REQ_ALLOC, POOL_INODE, $urandom, got);
    send_request(REQ_FREE, POOL_INODE, 32'd2, got);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure($urandom, $urandom_range(1, 40), $urandom_range(1, 40), 1'b0);
        1: configure(32'hFFFF_FFE0, $urandom_range(40, 140), $urandom_range(0, 8), 1'b0);
        2: configure($urandom, DATA_MAP_BITS_DEF, INODE_MAP_BITS_DEF, 1'b0);
        3: configure(32'd0, $urandom_range(0, 20), $urandom_range(60, 200), 1'b0);
        4: configure($urandom, 16383, $urandom_range(1, 30), 1'b0);
        default: configure($urandom, $urandom_range(1, 100), $urandom_range(1, 100), 1'b1);
      endcase
      // one phase runs with no bubbles on either side
      src_calm = (p == 2);
      snk_calm = (p == 2);
      repeat (PHASE_WORDS) random_request();
      wait_for_results();
    end
    src_calm = 1'b0;
    snk_calm = 1'b0;
  endtask

  // counts above the map size clamp to it; fill the inode map to the top
  task automatic test_inode_fill();
    outcome_t    got;
    int unsigned fulls;
    configure($urandom, 16383, 2047, 1'b0);
    fulls = 0;
    send_request(REQ_FREE, POOL_INODE, INODE_MAP_BITS_DEF, got);
    send_request(REQ_FREE, POOL_INODE, 32'd2047, got);
    send_request(REQ_FREE, POOL_DATA, base_q + DATA_MAP_BITS_DEF, got);
    send_request(REQ_FREE, POOL_DATA, base_q + 16383, got);
    while (fulls < 3) begin
      if ($urandom_range(9) == 0) begin
        send_request(REQ_ALLOC, POOL_DATA, $urandom, got);
      end else begin
        send_request(REQ_ALLOC, POOL_INODE, $urandom, got);
        if (got.status == ST_FULL) fulls++;
      end
    end
    send_request(REQ_FREE, POOL_INODE, INODE_MAP_BITS_DEF - 1, got);
    send_request(REQ_ALLOC, POOL_INODE, $urandom, got);
    send_request(REQ_ALLOC, POOL_INODE, $urandom, got);
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix();
    test_inode_fill();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
